// ----- rtl/core/spiral_scan_address_generator_assert.svh -----
// ----------------------------------------------------------------------------
// Spiral scan assertion macros
// Concurrent assertion shorthands used by the spiral scan address generator.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_SCAN_ADDRESS_GENERATOR_ASSERT_SVH
`define SPIRAL_SCAN_ADDRESS_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSAG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ssag_pkg.sv -----
// ----------------------------------------------------------------------------
// Spiral scan package
// Shared widths, codes, types and a helper function of the spiral scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssag_pkg;

  localparam int unsigned MaxSize = 64;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned RunW    = 7;
  localparam int unsigned CntW    = 12;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  localparam logic [IdxW-1:0] CfgIdxGridSize   = 2'd0;
  localparam logic [IdxW-1:0] CfgIdxSpiralMode = 2'd1;

  typedef enum logic [1:0] {
    HeadRight = 2'd0,
    HeadDown  = 2'd1,
    HeadLeft  = 2'd2,
    HeadUp    = 2'd3
  } head_e;

  typedef enum logic [ModeW-1:0] {
    ModeOutCcw = 2'd0,
    ModeOutCw  = 2'd1,
    ModeInCw   = 2'd2,
    ModeInCcw  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [CntW-1:0] count;
    logic            last;
  } cell_t;

  // Clamps the programmed side length into the supported range.
  function automatic logic [SizeW-1:0] side_len(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] n;
    n = size;
    if (n == '0) begin
      n = SizeW'(1);
    end else if (n > SizeW'(MaxSize)) begin
      n = SizeW'(MaxSize);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssag_walker.sv -----
// ----------------------------------------------------------------------------
// Spiral scan walker
// Holds the walk state and works out the next cell on every step request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssag_walker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                step_i,
  input  wire                                restart_i,
  input  wire logic [ssag_pkg::SizeW-1:0]    size_i,
  input  wire ssag_pkg::mode_e               mode_i,
  output ssag_pkg::cell_t                    cell_o
);

  logic [ssag_pkg::PosW-1:0] row_q, row_d, col_q, col_d, row_mv, col_mv;
  ssag_pkg::head_e           head_q, head_d;
  logic [ssag_pkg::RunW-1:0] run_q, run_d, pos_q, pos_d, pos_inc;
  logic [ssag_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      active_q, active_d;
  logic [ssag_pkg::SizeW-1:0] half, half_lo, n_m1;
  logic                      even;
  logic                      shorten, lengthen;
  logic [ssag_pkg::CntW:0]   total, cnt_next;
  logic                      last;

  always_comb begin
    half    = size_i >> 1;
    even    = ~size_i[0];
    half_lo = even ? (half - ssag_pkg::SizeW'(1)) : half;
    n_m1    = size_i - ssag_pkg::SizeW'(1);
    pos_inc = pos_q + ssag_pkg::RunW'(1);

    row_mv = row_q;
    col_mv = col_q;
    case (head_q)
      ssag_pkg::HeadRight: col_mv = col_q + ssag_pkg::PosW'(1);
      ssag_pkg::HeadDown:  row_mv = row_q + ssag_pkg::PosW'(1);
      ssag_pkg::HeadLeft:  col_mv = col_q - ssag_pkg::PosW'(1);
      default:             row_mv = row_q - ssag_pkg::PosW'(1);
    endcase

    shorten  = 1'b0;
    lengthen = 1'b0;
    head_d   = ssag_pkg::head_e'(head_q + 2'd1);
    case (mode_i)
      ssag_pkg::ModeOutCcw: begin
        lengthen = (head_q == ssag_pkg::HeadDown) || (head_q == ssag_pkg::HeadUp);
        head_d   = ssag_pkg::head_e'(head_q - 2'd1);
      end
      ssag_pkg::ModeOutCw: begin
        lengthen = (head_q == ssag_pkg::HeadDown) || (head_q == ssag_pkg::HeadUp);
      end
      ssag_pkg::ModeInCw: begin
        shorten = ((head_q == ssag_pkg::HeadRight) && (row_mv != '0)) ||
                  (head_q == ssag_pkg::HeadLeft);
      end
      default: begin
        shorten = (head_q == ssag_pkg::HeadRight) ||
                  ((head_q == ssag_pkg::HeadLeft) &&
                   (row_mv != n_m1[ssag_pkg::PosW-1:0]));
      end
    endcase

    if (restart_i || !active_q) begin
      row_d  = '0;
      col_d  = '0;
      head_d = ssag_pkg::HeadRight;
      run_d  = n_m1;
      pos_d  = '0;
      cnt_d  = '0;
      case (mode_i)
        ssag_pkg::ModeOutCcw: begin
          run_d = ssag_pkg::RunW'(1);
          row_d = half[ssag_pkg::PosW-1:0];
          col_d = half_lo[ssag_pkg::PosW-1:0];
        end
        ssag_pkg::ModeOutCw: begin
          run_d = ssag_pkg::RunW'(1);
          row_d = half_lo[ssag_pkg::PosW-1:0];
          col_d = half_lo[ssag_pkg::PosW-1:0];
        end
        ssag_pkg::ModeInCw: begin
        end
        default: begin
          row_d  = n_m1[ssag_pkg::PosW-1:0];
          col_d  = n_m1[ssag_pkg::PosW-1:0];
          head_d = ssag_pkg::HeadLeft;
        end
      endcase
    end else begin
      row_d = row_mv;
      col_d = col_mv;
      cnt_d = cnt_q + ssag_pkg::CntW'(1);
      run_d = run_q;
      if (pos_inc == run_q) begin
        pos_d = '0;
        if (lengthen) begin
          run_d = run_q + ssag_pkg::RunW'(1);
        end else if (shorten) begin
          run_d = run_q - ssag_pkg::RunW'(1);
        end
      end else begin
        pos_d  = pos_inc;
        head_d = head_q;
      end
    end

    total    = (ssag_pkg::CntW+1)'(size_i) * (ssag_pkg::CntW+1)'(size_i);
    cnt_next = (ssag_pkg::CntW+1)'(cnt_d) + (ssag_pkg::CntW+1)'(1);
    last     = (cnt_next >= total) || (cnt_d == '1);
    active_d = ~last;

    cell_o.row   = row_d;
    cell_o.col   = col_d;
    cell_o.count = cnt_d;
    cell_o.last  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      head_q   <= ssag_pkg::HeadRight;
      run_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (step_i) begin
      row_q    <= row_d;
      col_q    <= col_d;
      head_q   <= head_d;
      run_q    <= run_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssag_out.sv -----
// ----------------------------------------------------------------------------
// Spiral scan result stage
// Forms the linear address and holds each result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssag_out (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  load_i,
  input  wire ssag_pkg::cell_t                 cell_i,
  input  wire logic [ssag_pkg::SizeW-1:0]      size_i,
  input  wire                                  ready_i,
  output logic                                 valid_o,
  output logic [ssag_pkg::OutDataW-1:0]        data_o,
  output logic                                 last_o
);

  localparam int unsigned ProdW = ssag_pkg::PosW + ssag_pkg::SizeW;

  logic [ProdW-1:0]           addr_full;
  logic                       valid_q, valid_d;
  logic [ssag_pkg::PosW-1:0]  row_q, col_q;
  logic [ssag_pkg::AddrW-1:0] addr_q;
  logic [ssag_pkg::CntW-1:0]  cnt_q;
  logic                       last_q;

  assign addr_full = ProdW'(cell_i.row) * ProdW'(size_i) + ProdW'(cell_i.col);

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q  <= cell_i.row;
      col_q  <= cell_i.col;
      addr_q <= addr_full[ssag_pkg::AddrW-1:0];
      cnt_q  <= cell_i.count;
      last_q <= cell_i.last;
    end
  end

  assign valid_o = valid_q;
  assign last_o  = last_q;
  assign data_o  = {(ssag_pkg::OutDataW - 2*ssag_pkg::PosW - ssag_pkg::AddrW
                     - ssag_pkg::CntW)'(0), cnt_q, addr_q, col_q, row_q};

endmodule

`default_nettype wire

// ----- rtl/core/spiral_scan_address_generator.sv -----
// ----------------------------------------------------------------------------
// Spiral scan address generator
// One cell per request, result in the cycle after acceptance, one per cycle while the sink is ready.
// The rate is set by the single registered output stage after the walker.
// Reset clears the walk, sets grid size 8 and mode 0; no pass is active.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spiral_scan_address_generator_assert.svh"

module spiral_scan_address_generator (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ssag_pkg::IdxW-1:0]        cfg_index_i,
  input  wire logic [ssag_pkg::CfgW-1:0]        cfg_data_i,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: restart[0], zero fill[7:1].
  input  wire logic [ssag_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // Fields from bit 0: cell_row[5:0], cell_col[11:6], cell_address[23:12],
  // sequence_number[35:24], zero fill[39:36].
  output logic [ssag_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                  m_axis_tlast
);

  logic [ssag_pkg::SizeW-1:0] grid_size_q, side;
  ssag_pkg::mode_e            spiral_mode_q;
  logic                       step;
  ssag_pkg::cell_t            walk_cell;

  assign cfg_ready_o   = 1'b1;
  assign side          = ssag_pkg::side_len(grid_size_q);
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign step          = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= ssag_pkg::SizeW'(8);
      spiral_mode_q <= ssag_pkg::ModeOutCcw;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == ssag_pkg::CfgIdxGridSize) begin
        grid_size_q <= cfg_data_i;
      end else if (cfg_index_i == ssag_pkg::CfgIdxSpiralMode) begin
        spiral_mode_q <= ssag_pkg::mode_e'(cfg_data_i[ssag_pkg::ModeW-1:0]);
      end
    end
  end

  ssag_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (s_axis_tdata[0]),
    .size_i    (side),
    .mode_i    (spiral_mode_q),
    .cell_o    (walk_cell)
  );

  ssag_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .cell_i  (walk_cell),
    .size_i  (side),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  `SSAG_ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni,
                    m_axis_tvalid && !m_axis_tready, !s_axis_tready,
                    "input accepted while a result is stalled")
  `SSAG_ASSERT_NEXT(a_step_gives_result, clk_i, rst_ni,
                    step, m_axis_tvalid,
                    "accepted request produced no result")
  `SSAG_ASSERT_NEXT(a_restart_seq_zero, clk_i, rst_ni,
                    step && s_axis_tdata[0], m_axis_tdata[35:24] == 12'd0,
                    "restart did not begin at sequence number zero")

endmodule

`default_nettype wire

// ----- dv/spiral_scan_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral scan checker
// Watches the configuration, request and result channels of the spiral scan
// address generator. It keeps its own copy of the walk, works out the cell
// that each accepted request must produce, and compares every result with
// the oldest cell still owed.
// ----------------------------------------------------------------------------

module spiral_scan_checker
  import ssag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [IdxW-1:0]     cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);

  typedef struct packed {
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic [AddrW-1:0] addr;
    logic [CntW-1:0]  seq;
    logic             last;
  } visit_t;

  logic [SizeW-1:0] grid_size;
  mode_e            spiral_mode;
  logic [PosW-1:0]  walk_row;
  logic [PosW-1:0]  walk_col;
  head_e            walk_head;
  logic [RunW-1:0]  run_len;
  logic [RunW-1:0]  run_pos;
  logic [CntW-1:0]  visit_count;
  logic             pass_open;

  visit_t expected_visits[$];
  int     mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned seen,
                                 input int unsigned wanted);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, seen, wanted);
    mismatch_count++;
  endtask

  function automatic int unsigned grid_side();
    int unsigned n;
    n = grid_size;
    if (n == 0) begin
      n = 1;
    end else if (n > MaxSize) begin
      n = MaxSize;
    end
    return n;
  endfunction

  task automatic start_pass();
    int unsigned n;
    int unsigned half;
    bit          even;
    n           = grid_side();
    half        = n / 2;
    even        = (n % 2) == 0;
    walk_row    = '0;
    walk_col    = '0;
    walk_head   = HeadRight;
    run_len     = RunW'(n - 1);
    run_pos     = '0;
    visit_count = '0;
    pass_open   = 1'b1;
    case (spiral_mode)
      ModeOutCcw: begin
        run_len  = RunW'(1);
        walk_row = PosW'(half);
        walk_col = PosW'(even ? half - 1 : half);
      end
      ModeOutCw: begin
        run_len  = RunW'(1);
        walk_row = PosW'(even ? half - 1 : half);
        walk_col = PosW'(even ? half - 1 : half);
      end
      ModeInCcw: begin
        walk_row  = PosW'(n - 1);
        walk_col  = PosW'(n - 1);
        walk_head = HeadLeft;
      end
      default: begin
      end
    endcase
  endtask

  task automatic turn_corner();
    bit shorten;
    bit lengthen;
    shorten  = 1'b0;
    lengthen = 1'b0;
    case (spiral_mode)
      ModeOutCcw: begin
        lengthen  = (walk_head == HeadDown) || (walk_head == HeadUp);
        walk_head = head_e'(walk_head - 2'd1);
      end
      ModeOutCw: begin
        lengthen  = (walk_head == HeadDown) || (walk_head == HeadUp);
        walk_head = head_e'(walk_head + 2'd1);
      end
      ModeInCw: begin
        if (walk_head == HeadRight) begin
          shorten = walk_row != '0;
        end else if (walk_head == HeadLeft) begin
          shorten = 1'b1;
        end
        walk_head = head_e'(walk_head + 2'd1);
      end
      default: begin
        if (walk_head == HeadRight) begin
          shorten = 1'b1;
        end else if (walk_head == HeadLeft) begin
          shorten = walk_row != PosW'(grid_side() - 1);
        end
        walk_head = head_e'(walk_head + 2'd1);
      end
    endcase
    if (lengthen) begin
      run_len = run_len + 1'b1;
    end
    if (shorten) begin
      run_len = run_len - 1'b1;
    end
  endtask

  task automatic move_one();
    case (walk_head)
      HeadRight: walk_col = walk_col + 1'b1;
      HeadDown:  walk_row = walk_row + 1'b1;
      HeadLeft:  walk_col = walk_col - 1'b1;
      default:   walk_row = walk_row - 1'b1;
    endcase
    visit_count = visit_count + 1'b1;
    run_pos     = run_pos + 1'b1;
    if (run_pos == run_len) begin
      run_pos = '0;
      turn_corner();
    end
  endtask

  task automatic next_visit(input bit restart, output visit_t v);
    int unsigned n;
    if (restart || !pass_open) begin
      start_pass();
    end else begin
      move_one();
    end
    n      = grid_side();
    v.row  = walk_row;
    v.col  = walk_col;
    v.addr = AddrW'(walk_row * n + walk_col);
    v.seq  = visit_count;
    v.last = (visit_count + 1 >= n * n) || (visit_count == '1);
    if (v.last) begin
      pass_open = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    visit_t got;
    visit_t want;
    if (!rst_ni) begin
      grid_size   = SizeW'(8);
      spiral_mode = ModeOutCcw;
      walk_row    = '0;
      walk_col    = '0;
      walk_head   = HeadRight;
      run_len     = '0;
      run_pos     = '0;
      visit_count = '0;
      pass_open   = 1'b0;
      expected_visits.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.row  = m_tdata_i[PosW-1:0];
        got.col  = m_tdata_i[2*PosW-1:PosW];
        got.addr = m_tdata_i[2*PosW+AddrW-1:2*PosW];
        got.seq  = m_tdata_i[2*PosW+AddrW+CntW-1:2*PosW+AddrW];
        got.last = m_tlast_i;
        if (expected_visits.size() == 0) begin
          report_mismatch("unexpected result, sequence number", got.seq, 0);
        end else begin
          want = expected_visits.pop_front();
          if (got.row != want.row) report_mismatch("cell_row", got.row, want.row);
          if (got.col != want.col) report_mismatch("cell_col", got.col, want.col);
          if (got.addr != want.addr) report_mismatch("cell_address", got.addr, want.addr);
          if (got.seq != want.seq) report_mismatch("sequence_number", got.seq, want.seq);
          if (got.last != want.last) report_mismatch("last_cell", got.last, want.last);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        next_visit(s_tdata_i[0], want);
        expected_visits.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgIdxGridSize:   grid_size = cfg_data_i[SizeW-1:0];
          CfgIdxSpiralMode: spiral_mode = mode_e'(cfg_data_i[ModeW-1:0]);
          default: begin
          end
        endcase
      end
    end
    outstanding_o <= expected_visits.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral scan address generator testbench
// Programs grid sizes and modes between phases, sends step requests with
// random gaps and restarts, and stalls the result side at random, once for a
// long stretch. The checker beside the block predicts every cell.
// ----------------------------------------------------------------------------

module testbench;
  import ssag_pkg::*;

  localparam int unsigned RandomSteps   = 1700;
  localparam int unsigned HoldOffAt     = 600;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 500000;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index;
  logic [CfgW-1:0]     cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  int          mismatches;
  int          outstanding;
  int unsigned steps_sent = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;
  logic        hold_off = 1'b0;
  logic [CfgW-1:0] grid_now = CfgW'(8);

  spiral_scan_address_generator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  spiral_scan_checker u_scan_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_step(input bit restart);
    int unsigned         gap;
    logic [InDataW-2:0]  fill;
    gap  = gaps_on ? $urandom_range(0, 14) : 0;
    fill = ($urandom_range(0, 7) == 0) ? (InDataW - 1)'($urandom) : '0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fill, restart};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    steps_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CfgIdxGridSize) begin
      grid_now = value;
    end
  endtask

  task automatic set_grid_and_mode(input logic [CfgW-1:0] grid, input logic [CfgW-1:0] mode);
    settle();
    write_reg(CfgIdxGridSize, grid);
    write_reg(CfgIdxSpiralMode, mode);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_pass(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      push_step(i == 0);
    end
  endtask

  function automatic logic [CfgW-1:0] pick_grid();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return CfgW'($urandom_range(MaxSize + 1, 127));
      2:       return CfgW'(MaxSize);
      3:       return CfgW'($urandom_range(25, MaxSize - 1));
      4, 5:    return CfgW'($urandom_range(11, 24));
      default: return CfgW'($urandom_range(1, 10));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_done;
    int unsigned n;
    int unsigned len;
    bit          fresh;
    cfg_valid     <= 1'b0;
    cfg_index     <= CfgIdxGridSize;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_n         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Steps with no pass started, at the reset grid and mode.
    push_step(1'b0);
    push_step(1'b0);
    push_step(1'b0);

    // Every mode on a 2 by 2 grid, one step past the last cell each time.
    set_grid_and_mode(CfgW'(2), CfgW'(ModeOutCcw));
    run_pass(5);
    set_grid_and_mode(CfgW'(2), CfgW'(ModeOutCw));
    run_pass(5);
    set_grid_and_mode(CfgW'(2), CfgW'(ModeInCw) | CfgW'(7'h7C));
    run_pass(5);
    set_grid_and_mode(CfgW'(2), CfgW'(ModeInCcw));
    run_pass(5);

    // Grid size zero acts as one; oversized acts as the largest grid.
    set_grid_and_mode('0, CfgW'(ModeOutCw));
    push_step(1'b0);
    push_step(1'b1);
    set_grid_and_mode(CfgW'(127), CfgW'(ModeInCcw));
    push_step(1'b1);
    push_step(1'b0);

    random_done = 0;
    while (random_done < RandomSteps) begin
      settle();
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CfgIdxGridSize, pick_grid());
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CfgIdxSpiralMode, CfgW'($urandom));
      end
      cfg_valid <= 1'b0;
      n = (grid_now == 0) ? 1 : (grid_now > MaxSize) ? MaxSize : grid_now;
      if (n * n <= 144) begin
        len = n * n * $urandom_range(1, 2) + $urandom_range(0, 3);
      end else begin
        len = $urandom_range(20, 120);
      end
      fresh = $urandom_range(0, 3) != 0;
      for (int unsigned i = 0; i < len; i++) begin
        push_step((i == 0 && fresh) || ($urandom_range(0, 49) == 0));
      end
      random_done += len;
    end

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : pressure
    wait (steps_sent >= HoldOffAt);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : receiver
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, 14) : 0;
      if (stall != 0 || hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

endmodule

// ----- spiral_scan_address_generator.f -----
+incdir+rtl/core
rtl/core/ssag_pkg.sv
rtl/core/ssag_walker.sv
rtl/core/ssag_out.sv
rtl/core/spiral_scan_address_generator.sv
dv/spiral_scan_checker.sv
dv/testbench.sv
